FILE: src/coprime_near_sqrt_finder_unit_defines.svh
// assertion macros for the coprime near-root finder
`ifndef COPRIME_NEAR_SQRT_FINDER_UNIT_DEFINES_SVH
`define COPRIME_NEAR_SQRT_FINDER_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define CNSF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define CNSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cnsf_pkg.sv
// shared types, microcode program and constants for the coprime near-root finder
package cnsf_pkg;

    localparam int DEF_DATA_WIDTH = 32;
    localparam int PC_W           = 4;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_LEN,
        OP_ROOT,
        OP_INIT,
        OP_A_HALF,
        OP_B_HALF,
        OP_SUB,
        OP_NEXT,
        OP_EMIT_C,
        OP_EMIT_ONE
    } t_op;

    // jump conditions
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_WAIT,
        COND_M_LT2,
        COND_T_GT1,
        COND_BOTH_EVEN,
        COND_A_EVEN,
        COND_B_EVEN,
        COND_B_NZ,
        COND_A_NE1
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_ctrl;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic m_lt2;
        logic t_gt1;
        logic both_even;
        logic a_even;
        logic b_even;
        logic b_nz;
        logic a_ne1;
    } t_flags;

    // step addresses
    localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] STEP_CHECK    = 4'd1;
    localparam logic [PC_W-1:0] STEP_LEN      = 4'd2;
    localparam logic [PC_W-1:0] STEP_ROOT     = 4'd3;
    localparam logic [PC_W-1:0] STEP_INIT     = 4'd4;
    localparam logic [PC_W-1:0] STEP_EVEN     = 4'd5;
    localparam logic [PC_W-1:0] STEP_A_HALF   = 4'd6;
    localparam logic [PC_W-1:0] STEP_B_HALF   = 4'd7;
    localparam logic [PC_W-1:0] STEP_SUB      = 4'd8;
    localparam logic [PC_W-1:0] STEP_B_TEST   = 4'd9;
    localparam logic [PC_W-1:0] STEP_A_TEST   = 4'd10;
    localparam logic [PC_W-1:0] STEP_EMIT_C   = 4'd11;
    localparam logic [PC_W-1:0] STEP_NEXT     = 4'd12;
    localparam logic [PC_W-1:0] STEP_EMIT_ONE = 4'd13;

    // microcode program: bit length, root, then binary gcd per candidate
    function automatic t_ctrl ucode(input logic [PC_W-1:0] pc);
        t_ctrl w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
        case (pc)
            STEP_IDLE:     w = '{op: OP_LOAD,     cond: COND_WAIT,      target: STEP_IDLE};
            STEP_CHECK:    w = '{op: OP_NOP,      cond: COND_M_LT2,     target: STEP_EMIT_ONE};
            STEP_LEN:      w = '{op: OP_LEN,      cond: COND_T_GT1,     target: STEP_LEN};
            STEP_ROOT:     w = '{op: OP_ROOT,     cond: COND_NEVER,     target: STEP_IDLE};
            STEP_INIT:     w = '{op: OP_INIT,     cond: COND_NEVER,     target: STEP_IDLE};
            STEP_EVEN:     w = '{op: OP_NOP,      cond: COND_BOTH_EVEN, target: STEP_NEXT};
            STEP_A_HALF:   w = '{op: OP_A_HALF,   cond: COND_A_EVEN,    target: STEP_A_HALF};
            STEP_B_HALF:   w = '{op: OP_B_HALF,   cond: COND_B_EVEN,    target: STEP_B_HALF};
            STEP_SUB:      w = '{op: OP_SUB,      cond: COND_NEVER,     target: STEP_IDLE};
            STEP_B_TEST:   w = '{op: OP_NOP,      cond: COND_B_NZ,      target: STEP_B_HALF};
            STEP_A_TEST:   w = '{op: OP_NOP,      cond: COND_A_NE1,     target: STEP_NEXT};
            STEP_EMIT_C:   w = '{op: OP_EMIT_C,   cond: COND_ALWAYS,    target: STEP_IDLE};
            STEP_NEXT:     w = '{op: OP_NEXT,     cond: COND_ALWAYS,    target: STEP_INIT};
            STEP_EMIT_ONE: w = '{op: OP_EMIT_ONE, cond: COND_ALWAYS,    target: STEP_IDLE};
            default:       w = '{op: OP_NOP,      cond: COND_ALWAYS,    target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: src/cnsf_seq.sv
// microcode sequencer: step counter, program lookup and conditional jumps
module cnsf_seq
    import cnsf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_flags i_flags,
    output t_op    o_op,
    output logic   o_busy
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctrl           w;
    logic            accept;
    logic            jump;

    assign w      = ucode(r_pc);
    assign o_busy = (r_pc != STEP_IDLE);
    assign accept = i_start && !o_busy;

    // load only fires on the accepting cycle
    assign o_op = (w.op == OP_LOAD && !accept) ? OP_NOP : w.op;

    always_comb begin
        case (w.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_WAIT:      jump = !accept;
            COND_M_LT2:     jump = i_flags.m_lt2;
            COND_T_GT1:     jump = i_flags.t_gt1;
            COND_BOTH_EVEN: jump = i_flags.both_even;
            COND_A_EVEN:    jump = i_flags.a_even;
            COND_B_EVEN:    jump = i_flags.b_even;
            COND_B_NZ:      jump = i_flags.b_nz;
            COND_A_NE1:     jump = i_flags.a_ne1;
            default:        jump = 1'b1;
        endcase
        n_pc = jump ? w.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

FILE: src/cnsf_dp.sv
// datapath: modulus, candidate, gcd operands, bit-length counter and result register
module cnsf_dp
    import cnsf_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_op                   i_op,
    input  logic [DATA_WIDTH-1:0] i_modulus,
    output t_flags                o_flags,
    output logic [DATA_WIDTH-1:0] o_coprime,
    output logic                  o_valid
);

    localparam int LW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_m;
    logic [DATA_WIDTH-1:0] r_t;
    logic [DATA_WIDTH-1:0] r_c;
    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] r_b;
    logic [LW-1:0]         r_len;
    logic [DATA_WIDTH-1:0] r_coprime;
    logic                  r_valid;

    logic                  a_gt_b;
    logic [DATA_WIDTH-1:0] diff;
    logic [DATA_WIDTH-1:0] one;

    assign one    = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    assign a_gt_b = r_a > r_b;
    assign diff   = a_gt_b ? (r_a - r_b) : (r_b - r_a);

    assign o_flags.m_lt2     = (r_m[DATA_WIDTH-1:1] == '0);
    assign o_flags.t_gt1     = (r_t[DATA_WIDTH-1:1] != '0);
    assign o_flags.both_even = !r_a[0] && !r_b[0];
    assign o_flags.a_even    = !r_a[0];
    assign o_flags.b_even    = !r_b[0];
    assign o_flags.b_nz      = (r_b != '0);
    assign o_flags.a_ne1     = (r_a != one);

    assign o_coprime = r_coprime;
    assign o_valid   = r_valid;

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_m   <= i_modulus;
                r_t   <= i_modulus;
                r_len <= '0;
            end
            OP_LEN: begin
                r_t   <= r_t >> 1;
                r_len <= r_len + 1'b1;
            end
            OP_ROOT: begin
                r_c <= r_m >> r_len[LW-1:1];
            end
            OP_INIT: begin
                r_a <= r_c;
                r_b <= r_m;
            end
            OP_A_HALF: begin
                if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end
            end
            OP_B_HALF: begin
                if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end
            end
            OP_SUB: begin
                // keep the smaller operand in a, put the difference in b
                r_a <= a_gt_b ? r_b : r_a;
                r_b <= diff;
            end
            OP_NEXT: begin
                r_c <= r_c + 1'b1;
            end
            OP_EMIT_C: begin
                r_coprime <= r_c;
            end
            OP_EMIT_ONE: begin
                r_coprime <= one;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_op == OP_EMIT_C) || (i_op == OP_EMIT_ONE);
        end
    end

endmodule

FILE: src/coprime_near_sqrt_finder_unit.sv
// top level of the coprime near-root finder: sequencer, datapath and checks
//
//  channel  | signals                 | handshake
//  ---------+-------------------------+-----------------------------------------
//  item in  | start, busy, i_modulus  | taken at an edge with start high, busy low
//  item out | o_valid, o_coprime      | one-cycle strobe, cannot be held off
//
// per item: load, a check for moduli below two, a bit-length count of the modulus,
//   the root estimate, then for each candidate tried the binary gcd loop (halving and
//   subtract passes) until a coprime candidate is found, then the emit step;
//   moduli below two go straight to emitting one
// a single shared compare/subtract/shift unit runs the binary gcd, one step per cycle,
//   under the microcode program
// reset (synchronous, active low) returns the step counter to idle and drops o_valid
// busy stays high from the accepting edge until the result strobe; a new item
//   can be taken in the cycle the result is shown
`include "coprime_near_sqrt_finder_unit_defines.svh"

module coprime_near_sqrt_finder_unit
    import cnsf_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_modulus,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_coprime
);

    // datapath status back to the sequencer
    t_flags flags;
    // control word operation for this cycle
    t_op    op;

    // program counter, rom lookup and jump logic
    cnsf_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (flags),
        .o_op    (op),
        .o_busy  (busy)
    );

    // registers worked by the control word: modulus, candidate, gcd pair
    cnsf_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (op),
        .i_modulus (i_modulus),
        .o_flags   (flags),
        .o_coprime (o_coprime),
        .o_valid   (o_valid)
    );

    // an accepted item always puts the sequencer to work
    `CNSF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept without busy")
    // the result strobe only shows once the program is back at idle
    `CNSF_ASSERT_NOW(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")
    // one strobe per item: never two in a row
    `CNSF_ASSERT_NEXT(a_valid_single, i_clk, i_rst_n, o_valid, !o_valid, "repeated result")
    // a coprime value is never zero
    `CNSF_ASSERT_NOW(a_result_nz, i_clk, i_rst_n, o_valid, o_coprime != '0, "zero result")

endmodule
